FILE: rtl/stm_pkg.sv
package stm_pkg;

    localparam logic [2:0] OP_ADD_DRAWN   = 3'd0;
    localparam logic [2:0] OP_ADD_TMPL    = 3'd1;
    localparam logic [2:0] OP_CLEAR_DRAWN = 3'd2;
    localparam logic [2:0] OP_CLEAR_TMPL  = 3'd3;
    localparam logic [2:0] OP_EVAL        = 3'd4;

    localparam logic [1:0] CFG_WIDTH    = 2'd0;
    localparam logic [1:0] CFG_HEIGHT   = 2'd1;
    localparam logic [1:0] CFG_LINE_THR = 2'd2;
    localparam logic [1:0] CFG_VTX_THR  = 2'd3;

    localparam int CFG_W = 36;
    localparam int PIX_W = 13;
    localparam int CRD_W = 17;
    localparam int UNIT_W = 21;

    localparam logic [PIX_W-1:0] PIX_MAX = 13'd8191;
    localparam logic [UNIT_W-1:0] UV_MAX = 21'h100000;
    localparam logic [35:0] DIST_CAP = 36'hA_0000_0000;

    localparam logic [PIX_W-1:0] RST_WIDTH = 13'd1920;
    localparam logic [PIX_W-1:0] RST_HEIGHT = 13'd1080;
    localparam logic [35:0] RST_THR = 36'd42949673;

    localparam logic [4:0] DIV_CV_LAST = 5'd29;
    localparam logic [4:0] DIV_PJ_LAST = 5'd17;

    typedef enum logic [5:0] {
        S_IDLE, S_CV_RD, S_CV_LDX, S_CV_DIVX, S_CV_SVX, S_CV_LDY, S_CV_DIVY, S_CV_WR,
        S_L_RD, S_L_PLD, S_L_TRD, S_L_TLD,
        S_G_DIFF, S_G_EXDX, S_G_EYDY, S_G_DXDX, S_G_DYDY, S_G_DOT2, S_G_CLASS,
        S_G_XLO, S_G_XHI, S_G_XSUM, S_G_XLD, S_G_XDIV, S_G_XFIN,
        S_G_YLO, S_G_YHI, S_G_YSUM, S_G_YLD, S_G_YDIV, S_G_YFIN,
        S_D_DIFF, S_D_SQX, S_D_SQY, S_D_MIN,
        S_L_CHK, S_V_TRD, S_V_TLD, S_V_PRD, S_V_PLD, S_V_CHK, S_OUT
    } state_t;

    typedef enum logic [4:0] {
        DP_NOP, DP_CV_LDX, DP_CV_LDY, DP_DIV_STEP, DP_CV_SVX, DP_CV_WR,
        DP_P_LD_INIT, DP_P_LD, DP_T_SHIFT, DP_DIFF, DP_EXDX, DP_EYDY, DP_DXDX,
        DP_DYDY, DP_DOT2, DP_CLASS, DP_XLO, DP_XHI, DP_PSUM, DP_DIV_LDP, DP_XFIN,
        DP_YLO, DP_YHI, DP_YFIN, DP_V_LD, DP_D_DIFF, DP_SQX, DP_SQY, DP_MIN
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   drawn_we;
        logic   tmpl_we;
    } dp_cmd_t;

    typedef struct packed {
        logic dot1_le0;
        logic dot2_le_dot1;
        logic fail_line;
        logic fail_vtx;
    } dp_stat_t;

endpackage

FILE: rtl/stm_dp.sv
module stm_dp #(
    parameter int MAX_DRAWN = 256,
    parameter int MAX_TEMPLATE = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [1:0]                         cfg_index,
    input  logic [stm_pkg::CFG_W-1:0]          cfg_data,
    input  logic [16:0]                        coord_x,
    input  logic [16:0]                        coord_y,
    input  stm_pkg::dp_cmd_t                   cmd,
    input  logic [$clog2(MAX_DRAWN)-1:0]       d_addr,
    input  logic [$clog2(MAX_DRAWN)-1:0]       d_waddr,
    input  logic [$clog2(MAX_TEMPLATE)-1:0]    t_addr,
    input  logic [$clog2(MAX_TEMPLATE)-1:0]    t_waddr,
    output stm_pkg::dp_stat_t                  stat
);
    logic [12:0] width_reg, height_reg;
    logic [35:0] line_thr_reg, vtx_thr_reg;

    logic [25:0] drawn_mem [MAX_DRAWN];
    logic [41:0] unit_mem [MAX_DRAWN];
    logic [33:0] tmpl_mem [MAX_TEMPLATE];
    logic [25:0] dr_q_reg;
    logic [41:0] un_q_reg;
    logic [33:0] tm_q_reg;

    logic [20:0] pu_reg, pv_reg, utmp_reg;
    logic [16:0] au_reg, av_reg, bu_reg, bv_reg;
    logic signed [17:0] dx_reg, dy_reg;
    logic signed [22:0] ex_reg, ey_reg, cx_reg, cy_reg;
    logic signed [45:0] prod_reg;
    logic signed [53:0] acc_reg;
    logic signed [46:0] dot1_reg;
    logic [35:0] dot2_reg, best_reg;
    logic [35:0] rem_reg, den_reg;
    logic [29:0] num_reg, q_reg;

    logic [12:0] sw, sh;
    logic [12:0] px, py;
    logic signed [22:0] ma, mb;
    logic [16:0] adx, ady;
    logic [36:0] rem_sh;
    logic ge;
    logic [36:0] rem_sub;
    logic [20:0] q_sat;
    logic signed [22:0] qs;
    logic signed [53:0] dsum;

    assign sw = (width_reg == 13'd0) ? 13'd1 : width_reg;
    assign sh = (height_reg == 13'd0) ? 13'd1 : height_reg;
    assign px = (coord_x > 17'(stm_pkg::PIX_MAX)) ? stm_pkg::PIX_MAX : coord_x[12:0];
    assign py = (coord_y > 17'(stm_pkg::PIX_MAX)) ? stm_pkg::PIX_MAX : coord_y[12:0];
    assign adx = dx_reg[17] ? 17'(-dx_reg) : dx_reg[16:0];
    assign ady = dy_reg[17] ? 17'(-dy_reg) : dy_reg[16:0];
    assign rem_sh = {rem_reg, num_reg[29]};
    assign ge = rem_sh >= {1'b0, den_reg};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_sat = (q_reg > 30'(stm_pkg::UV_MAX)) ? stm_pkg::UV_MAX : q_reg[20:0];
    assign qs = $signed({5'b0, q_reg[17:0]});
    assign dsum = acc_reg + 54'(prod_reg);

    assign stat.dot1_le0 = dot1_reg <= 47'sd0;
    assign stat.dot2_le_dot1 = $signed({11'b0, dot2_reg}) <= dot1_reg;
    assign stat.fail_line = best_reg > line_thr_reg;
    assign stat.fail_vtx = best_reg > vtx_thr_reg;

    always_comb
    begin
        ma = 23'sd0;
        mb = 23'sd0;
        case (cmd.op)
            stm_pkg::DP_EXDX:
            begin
                ma = ex_reg;
                mb = 23'(dx_reg);
            end
            stm_pkg::DP_EYDY:
            begin
                ma = ey_reg;
                mb = 23'(dy_reg);
            end
            stm_pkg::DP_DXDX:
            begin
                ma = 23'(dx_reg);
                mb = 23'(dx_reg);
            end
            stm_pkg::DP_DYDY:
            begin
                ma = 23'(dy_reg);
                mb = 23'(dy_reg);
            end
            stm_pkg::DP_XLO:
            begin
                ma = $signed({6'b0, adx});
                mb = $signed({5'b0, dot1_reg[17:0]});
            end
            stm_pkg::DP_XHI:
            begin
                ma = $signed({6'b0, adx});
                mb = $signed({6'b0, dot1_reg[34:18]});
            end
            stm_pkg::DP_YLO:
            begin
                ma = $signed({6'b0, ady});
                mb = $signed({5'b0, dot1_reg[17:0]});
            end
            stm_pkg::DP_YHI:
            begin
                ma = $signed({6'b0, ady});
                mb = $signed({6'b0, dot1_reg[34:18]});
            end
            stm_pkg::DP_SQX:
            begin
                ma = ex_reg;
                mb = ex_reg;
            end
            stm_pkg::DP_SQY:
            begin
                ma = ey_reg;
                mb = ey_reg;
            end
            default:
            begin
                ma = 23'sd0;
                mb = 23'sd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= stm_pkg::RST_WIDTH;
            height_reg <= stm_pkg::RST_HEIGHT;
            line_thr_reg <= stm_pkg::RST_THR;
            vtx_thr_reg <= stm_pkg::RST_THR;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                stm_pkg::CFG_WIDTH: width_reg <= cfg_data[12:0];
                stm_pkg::CFG_HEIGHT: height_reg <= cfg_data[12:0];
                stm_pkg::CFG_LINE_THR: line_thr_reg <= cfg_data;
                stm_pkg::CFG_VTX_THR: vtx_thr_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drawn_we)
            drawn_mem[d_waddr] <= {px, py};
        if (cmd.tmpl_we)
            tmpl_mem[t_waddr] <= {coord_x, coord_y};
        if (cmd.op == stm_pkg::DP_CV_WR)
            unit_mem[d_addr] <= {utmp_reg, q_sat};
        dr_q_reg <= drawn_mem[d_addr];
        un_q_reg <= unit_mem[d_addr];
        tm_q_reg <= tmpl_mem[t_addr];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= ma * mb;
        case (cmd.op)
            stm_pkg::DP_CV_LDX:
            begin
                num_reg <= 30'({dr_q_reg[25:13], 16'b0}) + 30'(sw >> 1);
                den_reg <= 36'(sw);
                rem_reg <= '0;
                q_reg <= '0;
            end
            stm_pkg::DP_CV_LDY:
            begin
                num_reg <= 30'({dr_q_reg[12:0], 16'b0}) + 30'(sh >> 1);
                den_reg <= 36'(sh);
                rem_reg <= '0;
                q_reg <= '0;
            end
            stm_pkg::DP_DIV_STEP:
            begin
                rem_reg <= ge ? rem_sub[35:0] : rem_sh[35:0];
                num_reg <= {num_reg[28:0], 1'b0};
                q_reg <= {q_reg[28:0], ge};
            end
            stm_pkg::DP_CV_SVX: utmp_reg <= q_sat;
            stm_pkg::DP_P_LD_INIT:
            begin
                pu_reg <= un_q_reg[41:21];
                pv_reg <= un_q_reg[20:0];
                best_reg <= stm_pkg::DIST_CAP;
            end
            stm_pkg::DP_P_LD:
            begin
                pu_reg <= un_q_reg[41:21];
                pv_reg <= un_q_reg[20:0];
            end
            stm_pkg::DP_T_SHIFT:
            begin
                au_reg <= bu_reg;
                av_reg <= bv_reg;
                bu_reg <= tm_q_reg[33:17];
                bv_reg <= tm_q_reg[16:0];
            end
            stm_pkg::DP_DIFF:
            begin
                dx_reg <= $signed({1'b0, bu_reg}) - $signed({1'b0, au_reg});
                dy_reg <= $signed({1'b0, bv_reg}) - $signed({1'b0, av_reg});
                ex_reg <= $signed({2'b0, pu_reg}) - $signed({6'b0, au_reg});
                ey_reg <= $signed({2'b0, pv_reg}) - $signed({6'b0, av_reg});
            end
            stm_pkg::DP_EYDY: acc_reg <= 54'(prod_reg);
            stm_pkg::DP_DXDX: dot1_reg <= 47'(acc_reg) + 47'(prod_reg);
            stm_pkg::DP_DYDY: acc_reg <= 54'(prod_reg);
            stm_pkg::DP_DOT2: dot2_reg <= dsum[35:0];
            stm_pkg::DP_CLASS:
            begin
                if (stat.dot1_le0)
                begin
                    cx_reg <= $signed({6'b0, au_reg});
                    cy_reg <= $signed({6'b0, av_reg});
                end
                else
                begin
                    cx_reg <= $signed({6'b0, bu_reg});
                    cy_reg <= $signed({6'b0, bv_reg});
                end
            end
            // rounding bias of half the divisor, then the high partial product
            stm_pkg::DP_XHI, stm_pkg::DP_YHI:
                acc_reg <= 54'(prod_reg) + 54'(dot2_reg >> 1);
            stm_pkg::DP_PSUM: acc_reg <= acc_reg + (54'(prod_reg) <<< 18);
            stm_pkg::DP_DIV_LDP:
            begin
                rem_reg <= {1'b0, acc_reg[52:18]};
                num_reg <= {acc_reg[17:0], 12'b0};
                den_reg <= dot2_reg;
                q_reg <= '0;
            end
            stm_pkg::DP_XFIN: cx_reg <= $signed({6'b0, au_reg}) + (dx_reg[17] ? -qs : qs);
            stm_pkg::DP_YFIN: cy_reg <= $signed({6'b0, av_reg}) + (dy_reg[17] ? -qs : qs);
            stm_pkg::DP_V_LD:
            begin
                cx_reg <= $signed({6'b0, tm_q_reg[33:17]});
                cy_reg <= $signed({6'b0, tm_q_reg[16:0]});
                best_reg <= stm_pkg::DIST_CAP;
            end
            stm_pkg::DP_D_DIFF:
            begin
                ex_reg <= $signed({2'b0, pu_reg}) - cx_reg;
                ey_reg <= $signed({2'b0, pv_reg}) - cy_reg;
            end
            stm_pkg::DP_SQY: acc_reg <= 54'(prod_reg);
            stm_pkg::DP_MIN:
                if (dsum < $signed({18'b0, best_reg}))
                    best_reg <= dsum[35:0];
            default: ;
        endcase
    end

endmodule

FILE: rtl/stm_ctrl.sv
module stm_ctrl #(
    parameter int MAX_DRAWN = 256,
    parameter int MAX_TEMPLATE = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [2:0]                         opcode,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               match,
    output logic                               overflow,
    output stm_pkg::dp_cmd_t                   cmd,
    output logic [$clog2(MAX_DRAWN)-1:0]       d_addr,
    output logic [$clog2(MAX_DRAWN)-1:0]       d_waddr,
    output logic [$clog2(MAX_TEMPLATE)-1:0]    t_addr,
    output logic [$clog2(MAX_TEMPLATE)-1:0]    t_waddr,
    input  stm_pkg::dp_stat_t                  stat
);
    localparam int DA = $clog2(MAX_DRAWN);
    localparam int TA = $clog2(MAX_TEMPLATE);
    localparam int DW = $clog2(MAX_DRAWN + 1);
    localparam int TW = $clog2(MAX_TEMPLATE + 1);

    stm_pkg::state_t state_reg, state_next;
    logic [DW-1:0] dcnt_reg, dcnt_next, i_reg, i_next;
    logic [TW-1:0] tcnt_reg, tcnt_next, k_reg, k_next;
    logic [4:0] cnt_reg, cnt_next;
    logic ovf_reg, ovf_next, match_reg, match_next, phase_reg, phase_next;
    logic acc_in, i_last, k_last;

    assign acc_in = in_valid && !in_stall;
    assign i_last = (i_reg + 1'b1) == dcnt_reg;
    assign k_last = (k_reg + 1'b1) == tcnt_reg;

    assign in_stall = state_reg != stm_pkg::S_IDLE;
    assign out_valid = state_reg == stm_pkg::S_OUT;
    assign match = match_reg;
    assign overflow = ovf_reg;
    assign d_addr = i_reg[DA-1:0];
    assign d_waddr = dcnt_reg[DA-1:0];
    assign t_addr = k_reg[TA-1:0];
    assign t_waddr = tcnt_reg[TA-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stm_pkg::S_IDLE;
            dcnt_reg <= '0;
            tcnt_reg <= '0;
            i_reg <= '0;
            k_reg <= '0;
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            match_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dcnt_reg <= dcnt_next;
            tcnt_reg <= tcnt_next;
            i_reg <= i_next;
            k_reg <= k_next;
            cnt_reg <= cnt_next;
            ovf_reg <= ovf_next;
            match_reg <= match_next;
            phase_reg <= phase_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        dcnt_next = dcnt_reg;
        tcnt_next = tcnt_reg;
        i_next = i_reg;
        k_next = k_reg;
        cnt_next = cnt_reg;
        ovf_next = ovf_reg;
        match_next = match_reg;
        phase_next = phase_reg;
        case (state_reg)
            stm_pkg::S_IDLE:
                if (acc_in)
                begin
                    case (opcode)
                        stm_pkg::OP_ADD_DRAWN:
                            if (dcnt_reg < DW'(MAX_DRAWN))
                                dcnt_next = dcnt_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        stm_pkg::OP_ADD_TMPL:
                            if (tcnt_reg < TW'(MAX_TEMPLATE))
                                tcnt_next = tcnt_reg + 1'b1;
                            else
                                ovf_next = 1'b1;
                        stm_pkg::OP_CLEAR_DRAWN: dcnt_next = '0;
                        stm_pkg::OP_CLEAR_TMPL: tcnt_next = '0;
                        stm_pkg::OP_EVAL:
                        begin
                            i_next = '0;
                            k_next = '0;
                            phase_next = 1'b1;
                            if (dcnt_reg != '0)
                                state_next = stm_pkg::S_CV_RD;
                            else if (tcnt_reg == '0)
                            begin
                                match_next = 1'b1;
                                state_next = stm_pkg::S_OUT;
                            end
                            else
                                state_next = stm_pkg::S_V_TRD;
                        end
                        default: ;
                    endcase
                end
            stm_pkg::S_CV_RD: state_next = stm_pkg::S_CV_LDX;
            stm_pkg::S_CV_LDX:
            begin
                cnt_next = '0;
                state_next = stm_pkg::S_CV_DIVX;
            end
            stm_pkg::S_CV_DIVX:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stm_pkg::DIV_CV_LAST)
                    state_next = stm_pkg::S_CV_SVX;
            end
            stm_pkg::S_CV_SVX: state_next = stm_pkg::S_CV_LDY;
            stm_pkg::S_CV_LDY:
            begin
                cnt_next = '0;
                state_next = stm_pkg::S_CV_DIVY;
            end
            stm_pkg::S_CV_DIVY:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stm_pkg::DIV_CV_LAST)
                    state_next = stm_pkg::S_CV_WR;
            end
            stm_pkg::S_CV_WR:
                if (i_last)
                begin
                    i_next = '0;
                    phase_next = 1'b0;
                    state_next = stm_pkg::S_L_RD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = stm_pkg::S_CV_RD;
                end
            stm_pkg::S_L_RD: state_next = stm_pkg::S_L_PLD;
            stm_pkg::S_L_PLD:
            begin
                k_next = '0;
                state_next = (tcnt_reg < TW'(2)) ? stm_pkg::S_L_CHK : stm_pkg::S_L_TRD;
            end
            stm_pkg::S_L_TRD: state_next = stm_pkg::S_L_TLD;
            stm_pkg::S_L_TLD:
                if (k_reg == '0)
                begin
                    k_next = TW'(1);
                    state_next = stm_pkg::S_L_TRD;
                end
                else
                    state_next = stm_pkg::S_G_DIFF;
            stm_pkg::S_G_DIFF: state_next = stm_pkg::S_G_EXDX;
            stm_pkg::S_G_EXDX: state_next = stm_pkg::S_G_EYDY;
            stm_pkg::S_G_EYDY: state_next = stm_pkg::S_G_DXDX;
            stm_pkg::S_G_DXDX: state_next = stm_pkg::S_G_DYDY;
            stm_pkg::S_G_DYDY: state_next = stm_pkg::S_G_DOT2;
            stm_pkg::S_G_DOT2: state_next = stm_pkg::S_G_CLASS;
            stm_pkg::S_G_CLASS:
                state_next = (stat.dot1_le0 || stat.dot2_le_dot1) ? stm_pkg::S_D_DIFF
                                                                   : stm_pkg::S_G_XLO;
            stm_pkg::S_G_XLO: state_next = stm_pkg::S_G_XHI;
            stm_pkg::S_G_XHI: state_next = stm_pkg::S_G_XSUM;
            stm_pkg::S_G_XSUM: state_next = stm_pkg::S_G_XLD;
            stm_pkg::S_G_XLD:
            begin
                cnt_next = '0;
                state_next = stm_pkg::S_G_XDIV;
            end
            stm_pkg::S_G_XDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stm_pkg::DIV_PJ_LAST)
                    state_next = stm_pkg::S_G_XFIN;
            end
            stm_pkg::S_G_XFIN: state_next = stm_pkg::S_G_YLO;
            stm_pkg::S_G_YLO: state_next = stm_pkg::S_G_YHI;
            stm_pkg::S_G_YHI: state_next = stm_pkg::S_G_YSUM;
            stm_pkg::S_G_YSUM: state_next = stm_pkg::S_G_YLD;
            stm_pkg::S_G_YLD:
            begin
                cnt_next = '0;
                state_next = stm_pkg::S_G_YDIV;
            end
            stm_pkg::S_G_YDIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == stm_pkg::DIV_PJ_LAST)
                    state_next = stm_pkg::S_G_YFIN;
            end
            stm_pkg::S_G_YFIN: state_next = stm_pkg::S_D_DIFF;
            stm_pkg::S_D_DIFF: state_next = stm_pkg::S_D_SQX;
            stm_pkg::S_D_SQX: state_next = stm_pkg::S_D_SQY;
            stm_pkg::S_D_SQY: state_next = stm_pkg::S_D_MIN;
            stm_pkg::S_D_MIN:
                if (!phase_reg)
                begin
                    if (k_last)
                        state_next = stm_pkg::S_L_CHK;
                    else
                    begin
                        k_next = k_reg + 1'b1;
                        state_next = stm_pkg::S_L_TRD;
                    end
                end
                else if (i_last)
                    state_next = stm_pkg::S_V_CHK;
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = stm_pkg::S_V_PRD;
                end
            stm_pkg::S_L_CHK:
                if (stat.fail_line)
                begin
                    match_next = 1'b0;
                    state_next = stm_pkg::S_OUT;
                end
                else if (i_last)
                begin
                    i_next = '0;
                    k_next = '0;
                    phase_next = 1'b1;
                    if (tcnt_reg == '0)
                    begin
                        match_next = 1'b1;
                        state_next = stm_pkg::S_OUT;
                    end
                    else
                        state_next = stm_pkg::S_V_TRD;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                    state_next = stm_pkg::S_L_RD;
                end
            stm_pkg::S_V_TRD: state_next = stm_pkg::S_V_TLD;
            stm_pkg::S_V_TLD:
            begin
                i_next = '0;
                state_next = (dcnt_reg == '0) ? stm_pkg::S_V_CHK : stm_pkg::S_V_PRD;
            end
            stm_pkg::S_V_PRD: state_next = stm_pkg::S_V_PLD;
            stm_pkg::S_V_PLD: state_next = stm_pkg::S_D_DIFF;
            stm_pkg::S_V_CHK:
                if (stat.fail_vtx)
                begin
                    match_next = 1'b0;
                    state_next = stm_pkg::S_OUT;
                end
                else if (k_last)
                begin
                    match_next = 1'b1;
                    state_next = stm_pkg::S_OUT;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                    state_next = stm_pkg::S_V_TRD;
                end
            stm_pkg::S_OUT:
                if (!out_stall)
                    state_next = stm_pkg::S_IDLE;
            default: state_next = stm_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op = stm_pkg::DP_NOP;
        cmd.drawn_we = 1'b0;
        cmd.tmpl_we = 1'b0;
        case (state_reg)
            stm_pkg::S_IDLE:
            begin
                cmd.drawn_we = acc_in && opcode == stm_pkg::OP_ADD_DRAWN
                               && dcnt_reg < DW'(MAX_DRAWN);
                cmd.tmpl_we = acc_in && opcode == stm_pkg::OP_ADD_TMPL
                              && tcnt_reg < TW'(MAX_TEMPLATE);
            end
            stm_pkg::S_CV_LDX: cmd.op = stm_pkg::DP_CV_LDX;
            stm_pkg::S_CV_DIVX, stm_pkg::S_CV_DIVY,
            stm_pkg::S_G_XDIV, stm_pkg::S_G_YDIV: cmd.op = stm_pkg::DP_DIV_STEP;
            stm_pkg::S_CV_SVX: cmd.op = stm_pkg::DP_CV_SVX;
            stm_pkg::S_CV_LDY: cmd.op = stm_pkg::DP_CV_LDY;
            stm_pkg::S_CV_WR: cmd.op = stm_pkg::DP_CV_WR;
            stm_pkg::S_L_PLD: cmd.op = stm_pkg::DP_P_LD_INIT;
            stm_pkg::S_L_TLD: cmd.op = stm_pkg::DP_T_SHIFT;
            stm_pkg::S_G_DIFF: cmd.op = stm_pkg::DP_DIFF;
            stm_pkg::S_G_EXDX: cmd.op = stm_pkg::DP_EXDX;
            stm_pkg::S_G_EYDY: cmd.op = stm_pkg::DP_EYDY;
            stm_pkg::S_G_DXDX: cmd.op = stm_pkg::DP_DXDX;
            stm_pkg::S_G_DYDY: cmd.op = stm_pkg::DP_DYDY;
            stm_pkg::S_G_DOT2: cmd.op = stm_pkg::DP_DOT2;
            stm_pkg::S_G_CLASS: cmd.op = stm_pkg::DP_CLASS;
            stm_pkg::S_G_XLO: cmd.op = stm_pkg::DP_XLO;
            stm_pkg::S_G_XHI: cmd.op = stm_pkg::DP_XHI;
            stm_pkg::S_G_XSUM, stm_pkg::S_G_YSUM: cmd.op = stm_pkg::DP_PSUM;
            stm_pkg::S_G_XLD, stm_pkg::S_G_YLD: cmd.op = stm_pkg::DP_DIV_LDP;
            stm_pkg::S_G_XFIN: cmd.op = stm_pkg::DP_XFIN;
            stm_pkg::S_G_YLO: cmd.op = stm_pkg::DP_YLO;
            stm_pkg::S_G_YHI: cmd.op = stm_pkg::DP_YHI;
            stm_pkg::S_G_YFIN: cmd.op = stm_pkg::DP_YFIN;
            stm_pkg::S_D_DIFF: cmd.op = stm_pkg::DP_D_DIFF;
            stm_pkg::S_D_SQX: cmd.op = stm_pkg::DP_SQX;
            stm_pkg::S_D_SQY: cmd.op = stm_pkg::DP_SQY;
            stm_pkg::S_D_MIN: cmd.op = stm_pkg::DP_MIN;
            stm_pkg::S_V_TLD: cmd.op = stm_pkg::DP_V_LD;
            stm_pkg::S_V_PLD: cmd.op = stm_pkg::DP_P_LD;
            default: cmd.op = stm_pkg::DP_NOP;
        endcase
    end

endmodule

FILE: rtl/stroke_template_match.sv
// point loads and clears are handled in idle, one beat per cycle while no evaluate is running
// evaluate: pixel-to-unit conversion of every drawn point (30-step shared divider per axis),
// then segment tests of each drawn point, projections sharing that divider,
// then vertex tests of each template point; it stops early at the first failing point
// the result beat is held until taken; no input beat is taken during an evaluate
// rst_n (async, active low) empties both stores, clears overflow, restores register defaults
module stroke_template_match #(
    parameter int MAX_DRAWN = 256,
    parameter int MAX_TEMPLATE = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [2:0]                opcode,
    input  logic [16:0]               coord_x,
    input  logic [16:0]               coord_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      match,
    output logic                      overflow,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [stm_pkg::CFG_W-1:0] cfg_data
);
    stm_pkg::dp_cmd_t cmd;
    stm_pkg::dp_stat_t stat;
    logic [$clog2(MAX_DRAWN)-1:0] d_addr, d_waddr;
    logic [$clog2(MAX_TEMPLATE)-1:0] t_addr, t_waddr;

    stm_ctrl #(.MAX_DRAWN(MAX_DRAWN), .MAX_TEMPLATE(MAX_TEMPLATE)) u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
        .match(match), .overflow(overflow), .cmd(cmd), .d_addr(d_addr),
        .d_waddr(d_waddr), .t_addr(t_addr), .t_waddr(t_waddr), .stat(stat)
    );

    stm_dp #(.MAX_DRAWN(MAX_DRAWN), .MAX_TEMPLATE(MAX_TEMPLATE)) u_dp (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .coord_x(coord_x), .coord_y(coord_y), .cmd(cmd),
        .d_addr(d_addr), .d_waddr(d_waddr), .t_addr(t_addr), .t_waddr(t_waddr),
        .stat(stat)
    );

endmodule

FILE: rtl/stm_checker.sv
module stm_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic [2:0]                opcode,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic                      match,
    input logic                      overflow
);
    // a pending result blocks new input beats
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input taken while result pending");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(match) && $stable(overflow))
        else $error("stalled result beat changed");

    // overflow is sticky until reset
    assert property (@(posedge clk) disable iff (!rst_n) !$fell(overflow))
        else $error("overflow cleared");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode == stm_pkg::OP_EVAL |=> in_stall)
        else $error("evaluate did not hold off input");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && opcode != stm_pkg::OP_EVAL |=> !out_valid)
        else $error("result beat without evaluate");

endmodule

bind stroke_template_match stm_checker u_stm_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .out_valid(out_valid), .out_stall(out_stall),
    .match(match), .overflow(overflow)
);
